// File: hdl/sacl_pkg.sv
// shared constants and types for the set-associative cache lookup and fill unit
package sacl_pkg;

    localparam int SETS        = 64;
    localparam int WAYS        = 4;
    localparam int BLOCK_BYTES = 8;
    localparam int TAG_BITS    = 20;

    localparam int SET_AW  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_AW  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int BLOCK_W = 8 * BLOCK_BYTES;

    // operation codes
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    localparam logic [2:0] WAYS_IN_USE_RST = 3'd4;

    typedef logic [TAG_BITS-1:0] t_tag;
    typedef logic [BLOCK_W-1:0]  t_block;
    typedef logic [WAYS-1:0]     t_way_mask;

    typedef struct packed {
        t_tag   tag;
        t_block data;
    } t_line;

    typedef t_line [WAYS-1:0] t_row;

    // way selection from the compare stage
    typedef struct packed {
        logic              hit;
        logic [WAY_AW-1:0] hit_way;
        logic [WAY_AW-1:0] fill_way;
    } t_sel;

    // write request shared by the line ram and the valid bits
    typedef struct packed {
        logic              en;
        logic [SET_AW-1:0] row;
        t_way_mask         way_en;
    } t_wr;

endpackage

// File: hdl/sacl_way_ram.sv
// tag and data ram, one row per set, per-way write enables, registered read
module sacl_way_ram (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [sacl_pkg::SET_AW-1:0] i_rd_row,
    output sacl_pkg::t_row            o_rd_row,
    input  sacl_pkg::t_wr             i_wr,
    input  sacl_pkg::t_line           i_wr_line
);
    import sacl_pkg::*;

    t_row r_mem [SETS];
    t_row r_rd_row;

    always_ff @(posedge i_clk) begin
        for (int w = 0; w < WAYS; w++) begin
            if (i_wr.en && i_wr.way_en[w]) begin
                r_mem[i_wr.row][w] <= i_wr_line;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_row <= r_mem[i_rd_row];
        end
    end

    assign o_rd_row = r_rd_row;

endmodule

// File: hdl/sacl_valid_regs.sv
// per-set valid bits in flip-flops, cleared at reset
module sacl_valid_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [sacl_pkg::SET_AW-1:0] i_rd_row,
    output sacl_pkg::t_way_mask         o_valid,
    input  sacl_pkg::t_wr               i_wr
);
    import sacl_pkg::*;

    t_way_mask r_valid [SETS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '{default: '0};
        end else if (i_wr.en) begin
            r_valid[i_wr.row] <= r_valid[i_wr.row] | i_wr.way_en;
        end
    end

    assign o_valid = r_valid[i_rd_row];

endmodule

// File: hdl/sacl_lookup.sv
// parallel tag compare, lowest matching way and lowest invalid way
module sacl_lookup (
    input  sacl_pkg::t_way_mask i_valid,
    input  sacl_pkg::t_row      i_row,
    input  sacl_pkg::t_tag      i_tag,
    output sacl_pkg::t_sel      o_sel
);
    import sacl_pkg::*;

    always_comb begin
        o_sel = '0;
        // walk down so the lowest-numbered way wins; fill defaults to way 0
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (i_valid[w] && (i_row[w].tag == i_tag)) begin
                o_sel.hit     = 1'b1;
                o_sel.hit_way = WAY_AW'(w);
            end
            if (!i_valid[w]) begin
                o_sel.fill_way = WAY_AW'(w);
            end
        end
    end

endmodule

// File: hdl/set_assoc_cache_lookup_fill_unit.sv
// top level of the set-associative cache lookup and fill unit
// an accepted transaction reads the line ram, then its result is registered into the
//   output register, held back only while a stalled result still holds that register
// one transaction at a time: a new one waits for the read-modify-write of the line
//   ram (read at accept, compare and write-back after it)
// reset: synchronous, clears all valid bits at once (no clearing pass), ways_in_use = 4
module set_assoc_cache_lookup_fill_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [5:0]  i_set_index,
    input  logic [19:0] i_tag_value,
    input  logic [2:0]  i_byte_offset,
    input  logic [63:0] i_block_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_hit,
    output logic [7:0]  o_read_byte
);
    import sacl_pkg::*;

    // tag and data ram contents are not reset; only entries with valid set are used

    // configuration register
    logic [2:0]        r_ways_in_use;

    // in-flight transaction, held from the ram read until its result enters the output register
    logic              r_busy;
    logic              r_func;
    logic              r_set_ok;
    logic [SET_AW-1:0] r_row;
    t_tag              r_tag;
    logic [2:0]        r_off;
    t_block            r_blk;

    // output register
    logic              r_out_valid;
    logic              r_hit;
    logic [7:0]        r_byte;

    logic              w_accept;
    logic              w_done;
    logic              w_set_ok;
    logic              w_off_ok;
    logic              w_hit;
    logic [7:0]        w_byte;
    t_block            w_hit_block;
    t_row              w_rd_row;
    t_way_mask         w_valid;
    t_sel              w_sel;
    t_wr               w_wr;
    t_line             w_wr_line;

    // one transaction at a time: the next one enters once the current one has
    // written back, so a read never sees a stale row
    assign w_accept   = i_in_valid && !r_busy;
    assign o_in_stall = r_busy;

    // finish when the output register is free or being emptied this cycle
    assign w_done = r_busy && (!r_out_valid || !i_out_stall);

    // sets beyond the cache miss on lookup and drop inserts
    assign w_set_ok = 32'(i_set_index) < 32'(SETS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways_in_use <= WAYS_IN_USE_RST;
        end else if (i_cfg_we) begin
            r_ways_in_use <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end
    end

    // request payload capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func   <= i_func;
            r_set_ok <= w_set_ok;
            r_row    <= SET_AW'(i_set_index);
            r_tag    <= TAG_BITS'(i_tag_value);
            r_off    <= i_byte_offset;
            r_blk    <= BLOCK_W'(i_block_data);
        end
    end

    // line ram, read issued at the accept edge
    sacl_way_ram u_way_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_row  (SET_AW'(i_set_index)),
        .o_rd_row  (w_rd_row),
        .i_wr      (w_wr),
        .i_wr_line (w_wr_line)
    );

    sacl_valid_regs u_valid_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_row(r_row),
        .o_valid (w_valid),
        .i_wr    (w_wr)
    );

    sacl_lookup u_lookup (
        .i_valid (w_valid),
        .i_row   (w_rd_row),
        .i_tag   (r_tag),
        .o_sel   (w_sel)
    );

    // byte select on hit; offsets past the block read as zero
    assign w_off_ok    = 32'(r_off) < 32'(BLOCK_BYTES);
    assign w_hit_block = w_rd_row[w_sel.hit_way].data;
    assign w_byte      = 8'(w_hit_block >> {r_off, 3'b000});
    assign w_hit       = (r_func == FUNC_LOOKUP) && r_set_ok && w_sel.hit;

    // fill: lowest invalid way, else way 0; disabled when ways_in_use is zero
    always_comb begin
        w_wr.en     = w_done && (r_func == FUNC_INSERT) && r_set_ok &&
                      (r_ways_in_use != 3'd0);
        w_wr.row    = r_row;
        w_wr.way_en = w_wr.en ? (t_way_mask'(1) << w_sel.fill_way) : '0;
    end

    assign w_wr_line.tag  = r_tag;
    assign w_wr_line.data = r_blk;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_hit  <= w_hit;
            r_byte <= (w_hit && w_off_ok) ? w_byte : 8'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_read_byte = r_byte;

`ifndef SYNTHESIS
    // a new result only appears after a transaction was in flight
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_busy))
        else $error("result without transaction in flight");

    // an accepted transaction occupies the ram pipeline next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy)
        else $error("accepted transaction not tracked");

    // a miss or insert result carries a zero byte
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_read_byte == 8'd0))
        else $error("nonzero byte on miss");

    // a fill touches at most one way
    a_fill_one_way: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_wr.way_en))
        else $error("fill writes more than one way");

    // fills only happen while inserts are enabled
    a_fill_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> (r_ways_in_use != 3'd0) && (r_func == FUNC_INSERT))
        else $error("fill while inserts disabled");
`endif

endmodule
